>>> rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes, beat and control structs.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps
package spq_pkg;

	// queue geometry
	localparam int DEPTH       = 8;
	localparam int DATA_WIDTH  = 16;
	localparam int PRIO_WIDTH  = 16;
	localparam int COUNT_WIDTH = 4;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	// command codes
	typedef enum logic [0:0] {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_code_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// occupancy state of the controller
	typedef enum logic [1:0] {
		S_EMPTY,
		S_PARTIAL,
		S_FULL
	} occ_state_t;

	// input beat
	typedef struct packed {
		cmd_code_t                     command;
		logic [DATA_WIDTH-1:0]         data_in;
		logic signed [PRIO_WIDTH-1:0]  priority_in;
	} spq_in_t;

	// output beat
	typedef struct packed {
		status_t                       status;
		logic [DATA_WIDTH-1:0]         data_out;
		logic signed [PRIO_WIDTH-1:0]  priority_out;
		logic [COUNT_WIDTH-1:0]        count;
		logic                          full_res;
		logic                          empty_res;
	} spq_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic             insert;
		logic             remove;
		logic             load_rsp;
		status_t          status;
		logic [CNT_W-1:0] fill;
		logic [CNT_W-1:0] fill_next;
		logic             full_next;
		logic             empty_next;
	} spq_dp_cmd_t;

endpackage

>>> rtl/spq_ctrl.sv
// Controller of the sorted priority queue: occupancy state machine, fill count,
// command decode and output beat valid. Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  spq_pkg::cmd_code_t   command,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output spq_pkg::spq_dp_cmd_t dp_cmd
);

	spq_pkg::occ_state_t            state_q, state_d;
	logic [spq_pkg::CNT_W-1:0]      fill_q, fill_d;
	logic                           rsp_valid_q;
	logic                           accept;

	// take a new beat whenever the result register is free or draining
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign accept    = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;

	// decode the command against the occupancy state
	always_comb begin
		dp_cmd          = '0;
		dp_cmd.status   = spq_pkg::STAT_DONE;
		dp_cmd.fill     = fill_q;
		dp_cmd.load_rsp = accept;
		fill_d          = fill_q;
		if (accept) begin
			case (command)
				spq_pkg::CMD_ENQ: begin
					if (state_q == spq_pkg::S_FULL) begin
						dp_cmd.status = spq_pkg::STAT_FULL;
					end else begin
						dp_cmd.insert = 1'b1;
						fill_d        = fill_q + spq_pkg::CNT_W'(1);
					end
				end
				spq_pkg::CMD_DEQ: begin
					if (state_q == spq_pkg::S_EMPTY) begin
						dp_cmd.status = spq_pkg::STAT_EMPTY;
					end else begin
						dp_cmd.remove = 1'b1;
						fill_d        = fill_q - spq_pkg::CNT_W'(1);
					end
				end
				default: begin
					dp_cmd.status = spq_pkg::STAT_DONE;
				end
			endcase
		end
		dp_cmd.fill_next  = fill_d;
		dp_cmd.full_next  = (fill_d == spq_pkg::CNT_W'(spq_pkg::DEPTH));
		dp_cmd.empty_next = (fill_d == '0);
	end

	// next occupancy state from the updated count
	always_comb begin
		if (fill_d == '0) begin
			state_d = spq_pkg::S_EMPTY;
		end else if (fill_d == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
			state_d = spq_pkg::S_FULL;
		end else begin
			state_d = spq_pkg::S_PARTIAL;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::S_EMPTY;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/spq_dp.sv
// Datapath of the sorted priority queue: sorted slot registers with per-slot
// compare and shift, and the output beat register. Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_dp (
	input  logic                 clk,
	input  spq_pkg::spq_dp_cmd_t dp_cmd,
	input  spq_pkg::spq_in_t     cmd,
	output spq_pkg::spq_out_t    rsp
);

	logic [spq_pkg::DATA_WIDTH-1:0]        data_q [spq_pkg::DEPTH];
	logic signed [spq_pkg::PRIO_WIDTH-1:0] prio_q [spq_pkg::DEPTH];
	logic [spq_pkg::DEPTH-1:0]             gt;
	spq_pkg::spq_out_t                     rsp_q;

	// slot keeps its place when it is live and strictly outranks the new entry
	always_comb begin
		for (int i = 0; i < spq_pkg::DEPTH; i++) begin
			gt[i] = (spq_pkg::CNT_W'(i) < dp_cmd.fill) && (prio_q[i] > cmd.priority_in);
		end
	end

	// per-slot insert or shift
	for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_slot
		logic take_new;
		logic [spq_pkg::DATA_WIDTH-1:0]        up_data;
		logic signed [spq_pkg::PRIO_WIDTH-1:0] up_prio;
		logic [spq_pkg::DATA_WIDTH-1:0]        dn_data;
		logic signed [spq_pkg::PRIO_WIDTH-1:0] dn_prio;

		if (i == 0) begin : g_head
			assign take_new = 1'b1;
			assign up_data  = cmd.data_in;
			assign up_prio  = cmd.priority_in;
		end else begin : g_body
			assign take_new = gt[i-1];
			assign up_data  = data_q[i-1];
			assign up_prio  = prio_q[i-1];
		end

		if (i == spq_pkg::DEPTH - 1) begin : g_tail
			assign dn_data = data_q[i];
			assign dn_prio = prio_q[i];
		end else begin : g_mid
			assign dn_data = data_q[i+1];
			assign dn_prio = prio_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (dp_cmd.insert && !gt[i]) begin
				if (take_new) begin
					data_q[i] <= cmd.data_in;
					prio_q[i] <= cmd.priority_in;
				end else begin
					data_q[i] <= up_data;
					prio_q[i] <= up_prio;
				end
			end else if (dp_cmd.remove) begin
				data_q[i] <= dn_data;
				prio_q[i] <= dn_prio;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (dp_cmd.load_rsp) begin
			rsp_q.status       <= dp_cmd.status;
			rsp_q.data_out     <= dp_cmd.remove ? data_q[0] : '0;
			rsp_q.priority_out <= dp_cmd.remove ? prio_q[0] : '0;
			rsp_q.count        <= spq_pkg::COUNT_WIDTH'(dp_cmd.fill_next);
			rsp_q.full_res     <= dp_cmd.full_next;
			rsp_q.empty_res    <= dp_cmd.empty_next;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: joins controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
//   channel  signals                      beat type
//   command  cmd_valid, cmd_ready, cmd    spq_pkg::spq_in_t
//   result   rsp_valid, rsp_ready, rsp    spq_pkg::spq_out_t
//
// One command per cycle while results are taken: the queue update and the result
// register load both happen at the accepting edge; the result shows the next cycle.
// Every slot compares with the new priority in parallel and shifts in one step.
// Reset clears the count and the result valid; slot contents are not cleared.
// A stalled result holds cmd_ready low until it is taken or taken in the same cycle.
`timescale 1ns / 1ps
module sorted_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  spq_pkg::spq_in_t  cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output spq_pkg::spq_out_t rsp
);

	spq_pkg::spq_dp_cmd_t dp_cmd;

	// control
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.command   (cmd.command),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.dp_cmd    (dp_cmd)
	);

	// storage and result
	spq_dp u_dp (
		.clk    (clk),
		.dp_cmd (dp_cmd),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule
